// ----- src/ffra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants shared by the frame fenced ring allocator modules.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int FIELD_W = 24;
	localparam int DONE_W  = 3;
	localparam int CFG_DW  = 32;
	localparam int CFG_AW  = 3;

	localparam logic [FIELD_W-1:0] TOTAL_SIZE_RESET = 24'd65536;

	// Register index, taken from paddr[2].
	localparam logic REG_TOTAL_SIZE = 1'b0;

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_BEGIN = 2'd1,
		FUNC_END   = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic exec;
		logic walk_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
	} status_t;

endpackage

// ----- src/ffra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: takes an item, runs the slot walk for a begin frame and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module ffra_ctrl
	import ffra_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  func_t   func,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd,
	output logic    in_stall,
	output logic    out_valid
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (func == FUNC_BEGIN) ? ST_WALK : ST_RESP;
				end
			end
			ST_WALK: begin
				if (status.walk_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.exec = in_valid;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			ST_RESP: begin
				cmd.out_load = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

endmodule

// ----- src/ffra_datapath.sv -----
// ----------------------------------------------------------------------------
// ffra_datapath
// Head, free limit, frame records and result registers of the allocator.
// ----------------------------------------------------------------------------
module ffra_datapath
	import ffra_pkg::*;
#(
	parameter int SLOTS     = 3,
	parameter int ADDR_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  func_t              func,
	input  logic [FIELD_W-1:0] alloc_size,
	input  logic [DONE_W-1:0]  gpu_done_mask,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_data,
	output logic [FIELD_W-1:0] total_size,
	output logic [FIELD_W-1:0] grant_offset,
	output logic [FIELD_W-1:0] granted_size,
	output logic [FIELD_W-1:0] free_space
);

	localparam int AW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
	localparam int IW = $clog2(SLOTS);
	localparam logic [AW-1:0] TOTAL_RST = AW'(TOTAL_SIZE_RESET);
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

	logic [AW-1:0]      total_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      limit_q;
	logic [IW-1:0]      slot_idx_q;
	logic [SLOTS-1:0]   used_q;
	logic [AW-1:0]      slot_head_q [SLOTS];
	logic [DONE_W-1:0]  done_q;
	logic [IW-1:0]      walk_k_q;
	logic [IW-1:0]      walk_n_q;
	logic [AW-1:0]      res_offset_q;
	logic [AW-1:0]      res_granted_q;
	logic [FIELD_W-1:0] grant_offset_q;
	logic [FIELD_W-1:0] granted_size_q;
	logic [FIELD_W-1:0] free_space_q;

	logic [AW-1:0]    size_w;
	logic [AW:0]      sum_w;
	logic             alloc_ok;
	logic [AW-1:0]    alloc_off;
	logic [AW-1:0]    alloc_new;
	logic [AW-1:0]    reserve;
	logic [IW-1:0]    slot_next;
	logic [IW-1:0]    walk_k_next;
	logic [SLOTS-1:0] done_ext;

	// Slots beyond the width of the done mask never count as done.
	for (genvar i = 0; i < SLOTS; i++) begin : g_done
		if (i < DONE_W) begin : g_bit
			assign done_ext[i] = done_q[i];
		end else begin : g_none
			assign done_ext[i] = 1'b0;
		end
	end

	assign size_w      = AW'(alloc_size);
	assign sum_w       = {1'b0, head_q} + {1'b0, size_w};
	assign slot_next   = (slot_idx_q == LAST_SLOT) ? '0 : slot_idx_q + 1'b1;
	assign walk_k_next = (walk_k_q == LAST_SLOT) ? '0 : walk_k_q + 1'b1;
	assign status.walk_last = (walk_n_q == LAST_SLOT);

	always_comb begin
		alloc_ok  = 1'b1;
		alloc_off = head_q;
		alloc_new = sum_w[AW-1:0];
		if (head_q < limit_q) begin
			if (sum_w > {1'b0, limit_q}) begin
				alloc_ok = 1'b0;
			end
		end else if (sum_w > {1'b0, total_q}) begin
			if (size_w > limit_q) begin
				alloc_ok = 1'b0;
			end else begin
				alloc_off = '0;
				alloc_new = size_w;
			end
		end
	end

	assign reserve = (head_q < limit_q) ? (limit_q - head_q)
	                                    : (limit_q + total_q - head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST;
			head_q     <= '0;
			limit_q    <= TOTAL_RST;
			slot_idx_q <= '0;
			used_q     <= '0;
		end else if (cfg_we) begin
			total_q    <= AW'(cfg_data);
			head_q     <= '0;
			limit_q    <= AW'(cfg_data);
			slot_idx_q <= '0;
			used_q     <= '0;
		end else if (cmd.exec) begin
			unique case (func)
				FUNC_ALLOC: begin
					if (alloc_ok) begin
						head_q <= alloc_new;
					end
				end
				FUNC_BEGIN: begin
				end
				FUNC_END: begin
					used_q[slot_idx_q] <= 1'b1;
					slot_idx_q         <= slot_next;
				end
				FUNC_CLEAR: begin
					used_q <= '0;
				end
			endcase
		end else if (cmd.walk_step && used_q[walk_k_q] && done_ext[walk_k_q]) begin
			limit_q <= slot_head_q[walk_k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			done_q   <= gpu_done_mask;
			walk_k_q <= slot_idx_q;
			walk_n_q <= '0;
			if (func == FUNC_ALLOC) begin
				res_offset_q  <= alloc_off;
				res_granted_q <= alloc_ok ? size_w : '0;
			end else begin
				res_offset_q  <= head_q;
				res_granted_q <= '0;
			end
			if (func == FUNC_END) begin
				slot_head_q[slot_idx_q] <= head_q;
			end
		end
		if (cmd.walk_step) begin
			walk_k_q <= walk_k_next;
			walk_n_q <= walk_n_q + 1'b1;
		end
		if (cmd.out_load) begin
			grant_offset_q <= FIELD_W'(res_offset_q);
			granted_size_q <= FIELD_W'(res_granted_q);
			free_space_q   <= FIELD_W'(reserve);
		end
	end

	assign total_size   = FIELD_W'(total_q);
	assign grant_offset = grant_offset_q;
	assign granted_size = granted_size_q;
	assign free_space   = free_space_q;

endmodule

// ----- src/frame_fenced_ring_allocator_top.sv -----
// ----------------------------------------------------------------------------
// frame_fenced_ring_allocator_top
// Ring allocator with frame records that move the free limit at frame begin.
// ----------------------------------------------------------------------------
// Allocate, end frame and clear go from the accept to the result state, which
// loads the result once the output register is free. Begin frame first walks
// the frame records, one record a cycle, then loads its result the same way.
// One item is in work at a time; a new one is taken while a result waits.
// Reset sets total_size to 65536, head to 0, free limit to total_size and
// clears all frame records; a write sets the written size and does the same.
module frame_fenced_ring_allocator_top
	import ffra_pkg::*;
#(
	parameter int SLOTS     = 3,
	parameter int ADDR_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [FIELD_W-1:0] alloc_size,
	input  logic [DONE_W-1:0]  gpu_done_mask,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] grant_offset,
	output logic [FIELD_W-1:0] granted_size,
	output logic [FIELD_W-1:0] free_space,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [CFG_AW-1:0]  paddr,
	input  logic [CFG_DW-1:0]  pwdata,
	output logic [CFG_DW-1:0]  prdata,
	output logic               pready
);

	cmd_t               cmd;
	status_t            status;
	func_t              func_e;
	logic               cfg_we;
	logic [FIELD_W-1:0] total_size;

	assign func_e = func_t'(func);
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TOTAL_SIZE);
	assign prdata = (paddr[2] == REG_TOTAL_SIZE) ? CFG_DW'(total_size) : '0;

	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func_e),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	ffra_datapath #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.func          (func_e),
		.alloc_size    (alloc_size),
		.gpu_done_mask (gpu_done_mask),
		.cfg_we        (cfg_we),
		.cfg_data      (pwdata[FIELD_W-1:0]),
		.total_size    (total_size),
		.grant_offset  (grant_offset),
		.granted_size  (granted_size),
		.free_space    (free_space)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("Block took an item but did not go busy.");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("Result appeared without an item in work.");

	a_walk_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (in_stall && !cmd.exec && !cmd.out_load))
		else $error("Slot walk overlapped another command.");

endmodule

// ----- bench/tb_frame_fenced_ring_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_frame_fenced_ring_allocator_top
// Self-checking bench for the frame fenced ring allocator.
// Every accepted item runs through a bit-accurate allocator model, which
// queues the grant it should produce. Each result taken from the block is
// checked against the oldest queued grant. Phases cover several buffer
// sizes set over the register port. Each phase mixes well-formed frames
// (begin, allocates, end) with random noise items. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_frame_fenced_ring_allocator_top;
	import ffra_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 3;
	localparam int ADDR_BITS = 24;
	localparam int RANDOM_PHASE_ITEMS = 180;

	localparam logic [CFG_AW-1:0] ADDR_TOTAL_SIZE = {REG_TOTAL_SIZE, 2'b00};
	localparam logic [CFG_AW-1:0] ADDR_UNMAPPED   = 3'd4;

	class grant_scoreboard;
		typedef struct packed {
			logic [FIELD_W-1:0] offset;
			logic [FIELD_W-1:0] bytes;
			logic [FIELD_W-1:0] space;
		} grant_t;

		logic [FIELD_W-1:0] total_size;
		logic [FIELD_W-1:0] head;
		logic [FIELD_W-1:0] limit;
		int unsigned        frame_ptr;
		bit                 used [SLOTS];
		logic [FIELD_W-1:0] rec_head [SLOTS];
		grant_t             grant_q [$];
		int unsigned        errors;
		int unsigned        checked;
		int unsigned        granted;
		int unsigned        refused;
		int unsigned        wrapped;

		function new();
			errors  = 0;
			checked = 0;
			granted = 0;
			refused = 0;
			wrapped = 0;
			set_total(TOTAL_SIZE_RESET);
		endfunction

		function void clear_records();
			int i;
			for (i = 0; i < SLOTS; i++) begin
				used[i]     = 1'b0;
				rec_head[i] = total_size;
			end
		endfunction

		function void set_total(logic [FIELD_W-1:0] value);
			total_size = value;
			head       = '0;
			limit      = value;
			frame_ptr  = 0;
			clear_records();
		endfunction

		function logic [FIELD_W-1:0] reserve();
			if (head < limit) begin
				return limit - head;
			end
			return limit + total_size - head;
		endfunction

		function int pending();
			return grant_q.size();
		endfunction

		function void note_item(func_t f, logic [FIELD_W-1:0] sz, logic [DONE_W-1:0] done);
			grant_t           g;
			logic [FIELD_W:0] e;
			bit               ok;
			bit               wrap;
			int unsigned      k;
			int unsigned      n;

			g.offset = head;
			g.bytes  = '0;
			case (f)
				FUNC_ALLOC: begin
					e    = {1'b0, head} + {1'b0, sz};
					ok   = 1'b1;
					wrap = 1'b0;
					if (head < limit) begin
						if (e > {1'b0, limit}) ok = 1'b0;
					end else if (e > {1'b0, total_size}) begin
						if (sz > limit) begin
							ok = 1'b0;
						end else begin
							g.offset = '0;
							e        = {1'b0, sz};
							wrap     = 1'b1;
						end
					end
					if (ok) begin
						head    = e[FIELD_W-1:0];
						g.bytes = sz;
						granted++;
						if (wrap) wrapped++;
					end else begin
						refused++;
					end
				end
				FUNC_BEGIN: begin
					k = frame_ptr;
					for (n = 0; n < SLOTS; n++) begin
						if (used[k] && done[k]) limit = rec_head[k];
						k = (k + 1) % SLOTS;
					end
				end
				FUNC_END: begin
					used[frame_ptr]     = 1'b1;
					rec_head[frame_ptr] = head;
					frame_ptr           = (frame_ptr + 1) % SLOTS;
				end
				default: begin
					clear_records();
				end
			endcase
			g.space = reserve();
			grant_q.push_back(g);
		endfunction

		function void compare_field(string name, logic [FIELD_W-1:0] exp_v,
				logic [FIELD_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [FIELD_W-1:0] o, logic [FIELD_W-1:0] b,
				logic [FIELD_W-1:0] s);
			grant_t g;

			checked++;
			if (grant_q.size() == 0) begin
				$display("%0t: result with no item pending, expected none, actual %0d/%0d/%0d",
					$time, o, b, s);
				errors++;
				return;
			end
			g = grant_q.pop_front();
			compare_field("grant_offset", g.offset, o);
			compare_field("granted_size", g.bytes, b);
			compare_field("free_space", g.space, s);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic [FIELD_W-1:0] alloc_size;
	logic [DONE_W-1:0]  gpu_done_mask;
	logic               out_valid;
	logic               out_stall;
	logic [FIELD_W-1:0] grant_offset;
	logic [FIELD_W-1:0] granted_size;
	logic [FIELD_W-1:0] free_space;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [CFG_AW-1:0]  paddr;
	logic [CFG_DW-1:0]  pwdata;
	logic [CFG_DW-1:0]  prdata;
	logic               pready;

	grant_scoreboard sb;
	bit              quiet;
	int unsigned     items_sent;
	int unsigned     sizes_run;

	frame_fenced_ring_allocator_top #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.alloc_size    (alloc_size),
		.gpu_done_mask (gpu_done_mask),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.grant_offset  (grant_offset),
		.granted_size  (granted_size),
		.free_space    (free_space),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("[frame_fenced_ring_allocator_top] ERROR");
		$finish;
	end

	task automatic send_item(func_t f, logic [FIELD_W-1:0] sz, logic [DONE_W-1:0] done);
		int unsigned gap;

		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		alloc_size    <= sz;
		gpu_done_mask <= done;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(f, sz, done);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_total_size(logic [FIELD_W-1:0] exp_v);
		logic [CFG_DW-1:0] data;

		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_TOTAL_SIZE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.compare_field("total_size readback", exp_v, data[FIELD_W-1:0]);
	endtask

	task automatic set_total_size(logic [FIELD_W-1:0] value);
		reg_write(ADDR_TOTAL_SIZE, {8'($urandom()), value});
		sb.set_total(value);
		check_total_size(value);
		sizes_run++;
	endtask

	function automatic logic [FIELD_W-1:0] pick_size(logic [FIELD_W-1:0] total);
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 70) return FIELD_W'($urandom_range(0, total >> 2));
		if (r < 90) return FIELD_W'($urandom_range(0, total));
		return FIELD_W'($urandom());
	endfunction

	initial begin
		logic [FIELD_W-1:0]      totals [8];
		int unsigned             p;
		int unsigned             n;
		int unsigned             phase_end;

		totals = '{24'd1000, 24'd4096, 24'hFFFFFF, 24'd1, 24'd0, 24'd300, 24'd65536,
			24'd50000};
		sb            = new();
		quiet         = 1'b0;
		items_sent    = 0;
		sizes_run     = 1;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = FUNC_ALLOC;
		alloc_size    = '0;
		gpu_done_mask = '0;
		out_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		check_total_size(TOTAL_SIZE_RESET);
		reg_write(ADDR_UNMAPPED, $urandom());
		check_total_size(TOTAL_SIZE_RESET);

		send_item(FUNC_ALLOC, 24'd0, 3'd0);
		send_item(FUNC_ALLOC, 24'hFFFFFF, 3'd7);
		send_item(FUNC_ALLOC, 24'd65536, 3'd0);
		send_item(FUNC_ALLOC, 24'd0, 3'd0);
		send_item(FUNC_ALLOC, 24'd1, 3'd0);
		send_item(FUNC_END, 24'hFFFFFF, 3'd7);
		send_item(FUNC_ALLOC, 24'd1000, 3'd0);
		send_item(FUNC_END, 24'd0, 3'd0);
		send_item(FUNC_BEGIN, 24'd0, 3'd0);
		send_item(FUNC_BEGIN, 24'd0, 3'd1);
		send_item(FUNC_ALLOC, 24'd65000, 3'd0);
		send_item(FUNC_END, 24'd0, 3'd0);
		send_item(FUNC_END, 24'd0, 3'd0);
		send_item(FUNC_BEGIN, 24'hFFFFFF, 3'd7);
		send_item(FUNC_ALLOC, 24'h800000, 3'd0);
		send_item(FUNC_CLEAR, 24'hFFFFFF, 3'd7);
		send_item(FUNC_BEGIN, 24'd0, 3'd7);
		send_item(FUNC_ALLOC, 24'd65536, 3'd0);

		for (p = 0; p < 8; p++) begin
			wait_idle();
			quiet = (p % 3 == 1);
			set_total_size(totals[p]);
			phase_end = items_sent + RANDOM_PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 85) begin
					send_item(FUNC_BEGIN, FIELD_W'($urandom()), DONE_W'($urandom()));
					n = $urandom_range(1, 4);
					repeat (n) send_item(FUNC_ALLOC, pick_size(sb.total_size),
						DONE_W'($urandom()));
					send_item(FUNC_END, FIELD_W'($urandom()), DONE_W'($urandom()));
					if ($urandom_range(0, 19) == 0) begin
						send_item(FUNC_CLEAR, FIELD_W'($urandom()), DONE_W'($urandom()));
					end
				end else begin
					send_item(func_t'($urandom_range(0, 3)), FIELD_W'($urandom()),
						DONE_W'($urandom()));
				end
			end
		end
		wait_idle();

		$display("Sent %0d items over %0d buffer sizes, with register readback.",
			items_sent, sizes_run);
		$display("%0d grants (%0d wrapped to offset 0), %0d refusals, %0d results checked.",
			sb.granted, sb.wrapped, sb.refused, sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[frame_fenced_ring_allocator_top] OK");
		end else begin
			$display("[frame_fenced_ring_allocator_top] ERROR");
		end
		$finish;
	end

	initial begin
		int unsigned gap;

		@(posedge arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(grant_offset, granted_size, free_space);
		end
	end

endmodule
